// ----- src/dso_pkg.sv -----
// Shared types, constants and calendar tables for the date serial offset block.
package dso_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QY,
    S_QP,
    S_DBY,
    S_SER,
    S_SUM,
    S_Y400,
    S_Y100,
    S_Y4,
    S_Y1,
    S_MON,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QY,
    OP_QP,
    OP_DBY,
    OP_SER,
    OP_SUM,
    OP_STEP,
    OP_NEXT,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    PH_Y400,
    PH_Y100,
    PH_Y4,
    PH_Y1,
    PH_MON
  } phase_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic bad;
    logic out_free;
  } stat_t;

  localparam int SER_W = 21;
  localparam int SUM_W = 23;

  localparam logic [SER_W-1:0] DAYS_400 = 21'd146097;
  localparam logic [SER_W-1:0] DAYS_100 = 21'd36524;
  localparam logic [SER_W-1:0] DAYS_4   = 21'd1461;
  localparam logic [SER_W-1:0] DAYS_1   = 21'd365;

  // floor(x / 100) equals (x * 5243) >> 19 for every 12-bit x.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [19:0] SERIAL_MAX = 20'hFFFFF;

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Days of the year that lie before the first of month m.
  function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ----- src/date_serial_offset.sv -----
// Top level of the date serial offset block: stream ports, sequencer and datapath.
//
// The block takes one date and a signed day offset per input item and returns one result
// item: the shifted date, the serial day number of the given date (1 January of EPOCH_YEAR
// is day 1), a date-valid flag and an out-of-range flag. Items are processed one at a
// time. After the date check, the serial day number and the shift, an invalid date or a
// shift out of range goes straight to the result; otherwise the shifted day number is
// converted back by stepping over each 400-year, 100-year, 4-year and single year block
// and each month, one subtraction of a block length per cycle. The finished result sits
// in an output register, so the next item is accepted while it waits to be taken.
module date_serial_offset #(
  parameter int EPOCH_YEAR = 1901,
  parameter int LAST_YEAR  = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // year[11:0], month[15:12], day[20:16], offset_days[41:21]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_year[11:0], result_month[15:12],
                                  // result_day[20:16], serial_of_input[40:21]
  output logic [1:0]  out_tuser   // date_valid[0], out_of_range[1]
);

  dso_pkg::cmd_t  cmd;
  dso_pkg::stat_t stat;

  logic [11:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic [19:0] res_serial;
  logic        res_valid;
  logic        res_oor;

  dso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dso_dp #(
    .EPOCH_YEAR (EPOCH_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_year             (in_tdata[11:0]),
    .in_month            (in_tdata[15:12]),
    .in_day              (in_tdata[20:16]),
    .in_offset_days      ($signed(in_tdata[41:21])),
    .out_tready          (out_tready),
    .out_valid           (out_tvalid),
    .out_result_year     (res_year),
    .out_result_month    (res_month),
    .out_result_day      (res_day),
    .out_serial_of_input (res_serial),
    .out_date_valid      (res_valid),
    .out_out_of_range    (res_oor)
  );

  assign out_tdata = {7'd0, res_serial, res_day, res_month, res_year};
  assign out_tuser = {res_oor, res_valid};

  a_oor_needs_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("out_of_range reported for an invalid date");

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 48'd0)
    else $error("invalid date gave nonzero result fields");

  a_date_sane : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && !out_tuser[1]
      |-> out_tdata[15:12] >= 4'd1 && out_tdata[15:12] <= 4'd12 && out_tdata[20:16] >= 5'd1)
    else $error("shifted date has an impossible month or day");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

endmodule

// ----- src/dso_ctrl.sv -----
// Sequencer that steps the datapath through check, serial, shift and conversion back.
module dso_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  dso_pkg::stat_t stat,
  output dso_pkg::cmd_t  cmd
);

  dso_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dso_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = dso_pkg::OP_NONE;
    cmd.phase = dso_pkg::PH_Y400;
    in_tready = 1'b0;
    case (state_r)
      dso_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = dso_pkg::OP_LOAD;
          state_nxt = dso_pkg::S_QY;
        end
      end
      dso_pkg::S_QY: begin
        cmd.op    = dso_pkg::OP_QY;
        state_nxt = dso_pkg::S_QP;
      end
      dso_pkg::S_QP: begin
        cmd.op    = dso_pkg::OP_QP;
        state_nxt = dso_pkg::S_DBY;
      end
      dso_pkg::S_DBY: begin
        cmd.op    = dso_pkg::OP_DBY;
        state_nxt = dso_pkg::S_SER;
      end
      dso_pkg::S_SER: begin
        cmd.op    = dso_pkg::OP_SER;
        state_nxt = dso_pkg::S_SUM;
      end
      dso_pkg::S_SUM: begin
        cmd.op    = dso_pkg::OP_SUM;
        state_nxt = dso_pkg::S_Y400;
      end
      dso_pkg::S_Y400: begin
        cmd.phase = dso_pkg::PH_Y400;
        if (stat.bad) begin
          state_nxt = dso_pkg::S_DONE;
        end else if (stat.more) begin
          cmd.op = dso_pkg::OP_STEP;
        end else begin
          cmd.op    = dso_pkg::OP_NEXT;
          state_nxt = dso_pkg::S_Y100;
        end
      end
      dso_pkg::S_Y100: begin
        cmd.phase = dso_pkg::PH_Y100;
        if (stat.more) begin
          cmd.op = dso_pkg::OP_STEP;
        end else begin
          cmd.op    = dso_pkg::OP_NEXT;
          state_nxt = dso_pkg::S_Y4;
        end
      end
      dso_pkg::S_Y4: begin
        cmd.phase = dso_pkg::PH_Y4;
        if (stat.more) begin
          cmd.op = dso_pkg::OP_STEP;
        end else begin
          cmd.op    = dso_pkg::OP_NEXT;
          state_nxt = dso_pkg::S_Y1;
        end
      end
      dso_pkg::S_Y1: begin
        cmd.phase = dso_pkg::PH_Y1;
        if (stat.more) begin
          cmd.op = dso_pkg::OP_STEP;
        end else begin
          cmd.op    = dso_pkg::OP_NEXT;
          state_nxt = dso_pkg::S_MON;
        end
      end
      dso_pkg::S_MON: begin
        cmd.phase = dso_pkg::PH_MON;
        if (stat.more) begin
          cmd.op = dso_pkg::OP_STEP;
        end else begin
          state_nxt = dso_pkg::S_DONE;
        end
      end
      dso_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = dso_pkg::OP_OUT;
          state_nxt = dso_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dso_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/dso_dp.sv -----
// Datapath: date check, serial day number, shift and group-wise conversion back to a date.
module dso_dp #(
  parameter int EPOCH_YEAR = 1901,
  parameter int LAST_YEAR  = 4095
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dso_pkg::cmd_t       cmd,
  output dso_pkg::stat_t      stat,
  input  logic [11:0]         in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  input  logic signed [20:0]  in_offset_days,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [11:0]         out_result_year,
  output logic [3:0]          out_result_month,
  output logic [4:0]          out_result_day,
  output logic [19:0]         out_serial_of_input,
  output logic                out_date_valid,
  output logic                out_out_of_range
);

  localparam int EP  = EPOCH_YEAR - 1;
  localparam int DBE = EP * 365 + EP / 4 - EP / 100 + EP / 400;
  localparam int LP  = LAST_YEAR;
  localparam int LAST_SER_I = LP * 365 + LP / 4 - LP / 100 + LP / 400 - DBE;

  localparam logic [dso_pkg::SER_W-1:0]        DBE_V    = dso_pkg::SER_W'(DBE);
  localparam logic signed [dso_pkg::SUM_W-1:0] DBE_S    = dso_pkg::SUM_W'(DBE);
  localparam logic signed [dso_pkg::SUM_W-1:0] LAST_SER = dso_pkg::SUM_W'(LAST_SER_I);
  localparam logic [11:0] EPOCH_V = 12'(EPOCH_YEAR);
  localparam logic [11:0] LAST_V  = 12'(LAST_YEAR);

  logic [11:0]               year_r;
  logic [3:0]                month_r;
  logic [4:0]                day_r;
  logic signed [20:0]        offset_r;
  logic [5:0]                q_r;
  logic                      leap_in_r;
  logic                      valid_r;
  logic [dso_pkg::SER_W-1:0] dby_r;
  logic [dso_pkg::SER_W-1:0] serial_r;
  logic                      oor_r;
  logic [dso_pkg::SER_W-1:0] rem_r;
  logic [11:0]               yr_r;
  logic [4:0]                cnt_r;
  logic                      cent4_r;
  logic                      g24_r;
  logic                      leap_out_r;
  logic [3:0]                mon_r;
  logic                      out_valid_r;

  logic [11:0]                      p;
  logic [11:0]                      mul_in;
  logic [24:0]                      prod;
  logic [5:0]                       q;
  logic signed [dso_pkg::SUM_W-1:0] sum;
  logic signed [dso_pkg::SUM_W-1:0] abs_day;
  logic [dso_pkg::SER_W-1:0]        step_c;
  logic [11:0]                      yr_inc;
  logic                             cap_ok;
  logic [4:0]                       md_in;
  logic                             chk;

  assign p      = year_r - 12'd1;
  assign mul_in = (cmd.op == dso_pkg::OP_QY) ? year_r : p;
  assign prod   = {13'd0, mul_in} * {12'd0, dso_pkg::DIV100_MUL};
  assign q      = prod[dso_pkg::DIV100_SHIFT +: 6];

  assign sum     = $signed({2'b00, serial_r}) + $signed({{2{offset_r[20]}}, offset_r});
  assign abs_day = sum + DBE_S - dso_pkg::SUM_W'(1);

  assign md_in = dso_pkg::month_days(leap_in_r, month_r);
  assign chk   = (year_r >= EPOCH_V) && (year_r <= LAST_V) && (month_r >= 4'd1)
                 && (month_r <= 4'd12) && (day_r >= 5'd1) && (day_r <= md_in);

  always_comb begin
    step_c = dso_pkg::DAYS_1;
    yr_inc = 12'd0;
    cap_ok = 1'b1;
    case (cmd.phase)
      dso_pkg::PH_Y400: begin
        step_c = dso_pkg::DAYS_400;
        yr_inc = 12'd400;
      end
      dso_pkg::PH_Y100: begin
        step_c = dso_pkg::DAYS_100;
        yr_inc = 12'd100;
        cap_ok = cnt_r < 5'd3;
      end
      dso_pkg::PH_Y4: begin
        step_c = dso_pkg::DAYS_4;
        yr_inc = 12'd4;
      end
      dso_pkg::PH_Y1: begin
        step_c = dso_pkg::DAYS_1;
        yr_inc = 12'd1;
        cap_ok = cnt_r < 5'd3;
      end
      dso_pkg::PH_MON: begin
        step_c = {16'd0, dso_pkg::month_days(leap_out_r, mon_r)};
        cap_ok = mon_r < 4'd12;
      end
      default: begin
        cap_ok = 1'b0;
      end
    endcase
  end

  assign stat.more     = (rem_r >= step_c) && cap_ok;
  assign stat.bad      = !valid_r || oor_r;
  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      dso_pkg::OP_LOAD: begin
        year_r   <= in_year;
        month_r  <= in_month;
        day_r    <= in_day;
        offset_r <= in_offset_days;
      end
      dso_pkg::OP_QY: begin
        q_r <= q;
      end
      dso_pkg::OP_QP: begin
        // Divisible by 4, and not a century unless the century is divisible by 4.
        leap_in_r <= (year_r[1:0] == 2'b00)
                     && ((year_r != 12'(12'(q_r) * 12'd100)) || (q_r[1:0] == 2'b00));
        q_r <= q;
      end
      dso_pkg::OP_DBY: begin
        dby_r   <= dso_pkg::SER_W'(p) * dso_pkg::SER_W'(365) + dso_pkg::SER_W'(p[11:2])
                   - dso_pkg::SER_W'(q_r) + dso_pkg::SER_W'(q_r[5:2]);
        valid_r <= chk;
      end
      dso_pkg::OP_SER: begin
        serial_r <= dby_r - DBE_V
                    + dso_pkg::SER_W'(dso_pkg::days_before_month(leap_in_r, month_r))
                    + dso_pkg::SER_W'(day_r);
      end
      dso_pkg::OP_SUM: begin
        oor_r <= (sum < dso_pkg::SUM_W'(1)) || (sum > LAST_SER);
        // Day count from 1 January of year 1, starting at zero.
        rem_r <= abs_day[dso_pkg::SER_W-1:0];
        yr_r  <= 12'd1;
        cnt_r <= 5'd0;
        mon_r <= 4'd1;
      end
      dso_pkg::OP_STEP: begin
        rem_r <= rem_r - step_c;
        cnt_r <= cnt_r + 5'd1;
        yr_r  <= yr_r + yr_inc;
        if (cmd.phase == dso_pkg::PH_MON) begin
          mon_r <= mon_r + 4'd1;
        end
      end
      dso_pkg::OP_NEXT: begin
        cnt_r <= 5'd0;
        if (cmd.phase == dso_pkg::PH_Y100) begin
          cent4_r <= cnt_r == 5'd3;
        end
        if (cmd.phase == dso_pkg::PH_Y4) begin
          g24_r <= cnt_r == 5'd24;
        end
        // The last year of a four-year group is leap, except a century not divisible by 400.
        if (cmd.phase == dso_pkg::PH_Y1) begin
          leap_out_r <= (cnt_r == 5'd3) && (!g24_r || cent4_r);
        end
      end
      dso_pkg::OP_OUT: begin
        out_date_valid   <= valid_r;
        out_out_of_range <= valid_r && oor_r;
        if (!valid_r) begin
          out_serial_of_input <= 20'd0;
        end else if (serial_r > dso_pkg::SER_W'(dso_pkg::SERIAL_MAX)) begin
          out_serial_of_input <= dso_pkg::SERIAL_MAX;
        end else begin
          out_serial_of_input <= serial_r[19:0];
        end
        if (valid_r && !oor_r) begin
          out_result_year  <= yr_r;
          out_result_month <= mon_r;
          out_result_day   <= rem_r[4:0] + 5'd1;
        end else begin
          out_result_year  <= 12'd0;
          out_result_month <= 4'd0;
          out_result_day   <= 5'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == dso_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- dv/date_shift_checker.sv -----
// Checker for the date serial offset block: predicts each result and compares it on arrival.
module date_shift_checker #(
  parameter int EPOCH_YEAR = 1901,
  parameter int LAST_YEAR  = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [19:0] serial;
    logic        valid;
    logic        oor;
  } shifted_date_t;

  shifted_date_t expected_dates[$];
  int dates_taken = 0;
  int dates_returned = 0;

  initial fail_count = 0;
  assign pending = dates_taken - dates_returned;

  function automatic bit is_leap(longint y);
    return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
  endfunction

  function automatic longint month_length(longint y, longint m);
    longint n;
    case (m)
      2:              n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:    n = 30;
      default:        n = 31;
    endcase
    return n;
  endfunction

  // Days of all years from year 1 up to, but not including, year y.
  function automatic longint days_to_year(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic shifted_date_t shift_date(logic [11:0] yr, logic [3:0] mo,
                                               logic [4:0] dy, logic signed [20:0] ofs);
    shifted_date_t r;
    longint y, m, d, k, serial, sum, last_serial;
    r = '0;
    y = yr;
    m = mo;
    d = dy;
    if (y < EPOCH_YEAR || y > LAST_YEAR || m < 1 || m > 12 || d < 1 ||
        d > month_length(y, m)) begin
      return r;
    end
    serial = days_to_year(y) - days_to_year(EPOCH_YEAR);
    for (k = 1; k < m; k++) begin
      serial += month_length(y, k);
    end
    serial += d;
    r.serial = (serial > 64'hFFFFF) ? 20'hFFFFF : serial[19:0];
    r.valid  = 1'b1;

    last_serial = days_to_year(LAST_YEAR + 1) - days_to_year(EPOCH_YEAR);
    sum = serial + ofs;
    if (sum < 1 || sum > last_serial) begin
      r.oor = 1'b1;
      return r;
    end
    y = EPOCH_YEAR;
    while (sum > (is_leap(y) ? 366 : 365)) begin
      sum -= is_leap(y) ? 366 : 365;
      y++;
    end
    m = 1;
    while (m < 12 && sum > month_length(y, m)) begin
      sum -= month_length(y, m);
      m++;
    end
    r.yr = y[11:0];
    r.mo = m[3:0];
    r.dy = sum[4:0];
    return r;
  endfunction

  function automatic int field_differs(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    shifted_date_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result item with nothing expected, data %h user %b",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_dates.pop_front();
          errs += field_differs("result_year", want.yr, out_tdata[11:0]);
          errs += field_differs("result_month", want.mo, out_tdata[15:12]);
          errs += field_differs("result_day", want.dy, out_tdata[20:16]);
          errs += field_differs("serial_of_input", want.serial, out_tdata[40:21]);
          errs += field_differs("date_valid", want.valid, out_tuser[0]);
          errs += field_differs("out_of_range", want.oor, out_tuser[1]);
        end
        dates_returned <= dates_returned + 1;
      end
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(shift_date(in_tdata[11:0], in_tdata[15:12],
                                            in_tdata[20:16], in_tdata[41:21]));
        dates_taken <= dates_taken + 1;
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the date serial offset block: clock, reset, stimulus and verdict.
module tb_top;

  localparam int EPOCH_YEAR     = 1901;
  localparam int LAST_YEAR      = 4095;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;

  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_BLOCKED
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  ready_mode_t stall_mode = RDY_ALWAYS;

  always #2 clk = ~clk;

  date_serial_offset #(
    .EPOCH_YEAR(EPOCH_YEAR),
    .LAST_YEAR (LAST_YEAR)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  date_shift_checker #(
    .EPOCH_YEAR(EPOCH_YEAR),
    .LAST_YEAR (LAST_YEAR)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver switches between stall modes for random stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= ready_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(1, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:    out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[date_serial_offset] ERROR");
      $finish;
    end
  end

  function automatic logic leap_of(logic [11:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Items go out in bursts; a gap opens whenever the current burst is used up.
  task automatic send_date(input logic [11:0] yr, input logic [3:0] mo,
                           input logic [4:0] dy, input logic [20:0] ofs);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, ofs, dy, mo, yr};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  mlen;
    logic [20:0] ofs;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Raw noise over every field, mostly invalid dates.
      y   = 12'($urandom);
      m   = 4'($urandom);
      d   = 5'($urandom);
      ofs = 21'($urandom);
    end else begin
      if (pick < 24) begin
        y = 12'($urandom_range(0, 1) ? EPOCH_YEAR + $urandom_range(0, 3)
                                     : LAST_YEAR - $urandom_range(0, 3));
      end else begin
        y = 12'($urandom_range(EPOCH_YEAR, LAST_YEAR));
      end
      m    = 4'($urandom_range(1, 12));
      mlen = dso_pkg::month_days(leap_of(y), m);
      if (pick < 30) begin
        d = mlen;
      end else if (pick < 34) begin
        // Broken dates just past the end of the month or on day zero.
        d = $urandom_range(0, 1) ? mlen + 5'd1 : 5'd0;
      end else begin
        d = 5'($urandom_range(1, mlen));
      end
      case ($urandom_range(0, 4))
        0:       ofs = $urandom_range(0, 1) ? 21'd1 : 21'h1FFFFF;
        1:       ofs = 21'($urandom_range(0, 800) - 400);
        2:       ofs = 21'($urandom_range(0, 100000) - 50000);
        3:       ofs = 21'($urandom_range(0, 1600000) - 800000);
        default: ofs = 21'($urandom);
      endcase
    end
    send_date(y, m, d, ofs);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_date(12'd1901, 4'd1, 5'd1, 21'd0);
    send_date(12'd1901, 4'd1, 5'd1, 21'h1FFFFF);
    send_date(12'd1901, 4'd1, 5'd1, 21'h0FFFFF);
    send_date(12'd1901, 4'd1, 5'd1, 21'd801000);
    send_date(12'd4095, 4'd12, 5'd31, 21'd0);
    send_date(12'd4095, 4'd12, 5'd31, 21'd1);
    send_date(12'd4095, 4'd12, 5'd31, 21'h100000);
    send_date(12'd4095, 4'd12, 5'd31, 21'h1FFFFF);
    send_date(12'd2000, 4'd2, 5'd29, 21'd0);
    send_date(12'd2000, 4'd2, 5'd28, 21'd1);
    send_date(12'd2000, 4'd3, 5'd1, 21'h1FFFFF);
    send_date(12'd2100, 4'd2, 5'd29, 21'd0);
    send_date(12'd2100, 4'd2, 5'd28, 21'd1);
    send_date(12'd2024, 4'd2, 5'd29, 21'd365);
    send_date(12'd2023, 4'd2, 5'd29, 21'd0);
    send_date(12'd2400, 4'd2, 5'd29, 21'd0);
    send_date(12'd1999, 4'd12, 5'd31, 21'd1);
    send_date(12'd1900, 4'd12, 5'd31, 21'd1);
    send_date(12'd0, 4'd0, 5'd0, 21'd0);
    send_date(12'd2010, 4'd13, 5'd1, 21'd0);
    send_date(12'hFFF, 4'hF, 5'd31, 21'h1FFFFF);
    send_date(12'd2010, 4'd4, 5'd31, 21'd0);
    send_date(12'd2010, 4'd1, 5'd31, 21'd0);
    send_date(12'd2010, 4'd6, 5'd0, 21'd0);

    repeat (RANDOM_ITEMS) send_random();

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[date_serial_offset] OK");
    end else begin
      $display("[date_serial_offset] ERROR");
    end
    $finish;
  end

endmodule
